// ===== rtl/dpr_pkg.sv =====
package dpr_pkg;

  // One input beat: a start flag with an initial pose, a target pose, a nominal turn rate and feedback gains.
  typedef struct packed {
    logic               start_req;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_heading;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_heading;
    logic signed [31:0] nominal_rate;
    logic signed [31:0] gain_x;
    logic signed [31:0] gain_y;
    logic signed [31:0] gain_heading;
  } in_beat_t;

  // One result beat: the advanced pose, the applied turn rate and whether it was clamped.
  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic signed [31:0] next_heading;
    logic signed [31:0] applied_rate;
    logic               rate_clamped;
  } out_beat_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CRUISE_SPEED = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP    = 2'd1;
  localparam logic [1:0] CFG_RATE_UPPER   = 2'd2;
  localparam logic [1:0] CFG_RATE_LOWER   = 2'd3;

  // Angle constants in Q2.30.
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dubins_projection_rollout_unit.sv =====
// A turning step runs the angle reducer and CORDIC on the old heading, the serial divider,
// then the reducer and CORDIC on the new heading; a zero rate skips divider and second pass.
// The input stalls from acceptance until the result is staged and takes the next beat in the
// cycle after, so a new beat is never taken before the last one is through.
// The serial divider (one quotient bit a cycle), the CORDIC (one rotation a cycle) and the
// angle reducer (one compare and subtract a cycle) do the iterative work of the step.
module dubins_projection_rollout_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dpr_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpr_pkg::out_beat_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  // Reset: asynchronous, active low; pose clears to zero, configuration takes its defaults.

  // Shift from the pose format up to Q2.30, and the widths that follow from it.
  localparam int SH        = 30 - FRAC_BITS;
  localparam int MW        = 62 - FRAC_BITS;
  localparam int RED_STEPS = 30 - FRAC_BITS;
  localparam int KW        = $clog2(RED_STEPS);
  localparam int CW        = $clog2(CORDIC_STEPS);
  localparam int DW        = 31 + FRAC_BITS;
  localparam int DCW       = $clog2(DW);

  // Sequencer states.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_M0    = 5'd1;
  localparam logic [4:0] S_M1    = 5'd2;
  localparam logic [4:0] S_M2    = 5'd3;
  localparam logic [4:0] S_CLAMP = 5'd4;
  localparam logic [4:0] S_M3    = 5'd5;
  localparam logic [4:0] S_YAW   = 5'd6;
  localparam logic [4:0] S_RSET  = 5'd7;
  localparam logic [4:0] S_RED   = 5'd8;
  localparam logic [4:0] S_FOLD1 = 5'd9;
  localparam logic [4:0] S_FOLD2 = 5'd10;
  localparam logic [4:0] S_CORD  = 5'd11;
  localparam logic [4:0] S_CEND  = 5'd12;
  localparam logic [4:0] S_Z0    = 5'd13;
  localparam logic [4:0] S_Z1    = 5'd14;
  localparam logic [4:0] S_Z2    = 5'd15;
  localparam logic [4:0] S_Z3    = 5'd16;
  localparam logic [4:0] S_DSET  = 5'd17;
  localparam logic [4:0] S_DIV   = 5'd18;
  localparam logic [4:0] S_DEND  = 5'd19;
  localparam logic [4:0] S_A1    = 5'd20;
  localparam logic [4:0] S_A2    = 5'd21;
  localparam logic [4:0] S_A3    = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  // Saturate a 33-bit sum or difference to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Fixed-point product, floored after the shift and saturated.
  function automatic logic signed [31:0] fxmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    logic signed [65:0] p;
    logic signed [31:0] r;
    p = (a * b) >>> FRAC_BITS;
    if (p > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (p < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = p[31:0];
    end
    return r;
  endfunction

  // Round a Q2.30 CORDIC output to nearest in the pose format.
  function automatic logic signed [31:0] rnd30(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + (34'sd1 <<< (SH - 1))) >>> SH;
    return t[31:0];
  endfunction

  // Configuration registers.
  logic [30:0]        cs_q, ts_q;
  logic signed [31:0] hi_q, lo_q;

  // Kept pose.
  logic signed [31:0] px_q, py_q, ph_q;

  // Beat held while it is worked on.
  dpr_pkg::in_beat_t  beat_q;

  logic [4:0]         state_q, state_d;
  logic signed [31:0] acc_q, t_q, t_d, rate_q, nyaw_q, ang_q, d_q, nx_q, ny_q;
  logic               clamp_q, pass_q;
  logic signed [31:0] s0_q, c0_q, s1_q, c1_q;

  // Angle reducer and CORDIC.
  logic [MW-1:0]      m_q, tp_k;
  logic               neg_q, flip_q;
  logic [KW-1:0]      k_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [CW-1:0]      i_q;

  // Serial divider: the dividend register fills with quotient bits.
  logic [DW-1:0]      dvd_q;
  logic [31:0]        rem_q, dvs_q;
  logic [32:0]        trial;
  logic [DCW-1:0]     dc_q;

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;

  // Combinational helpers.
  logic signed [31:0] raw, rclamp, absang, radius;
  logic signed [33:0] zs, zw;

  logic [32:0] Q30_TWO_PI_U;

  dpr_pkg::out_beat_t out_q;
  logic               out_valid_q;
  logic               accept, emit;

  assign Q30_TWO_PI_U = dpr_pkg::Q30_TWO_PI[32:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign emit        = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The one multiplier is shared by every product of the step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M0: begin
        mul_a = 33'(beat_q.gain_x);
        mul_b = 33'(sat33(33'(beat_q.target_x) - 33'(px_q)));
      end
      S_M1: begin
        mul_a = 33'(beat_q.gain_y);
        mul_b = 33'(sat33(33'(beat_q.target_y) - 33'(py_q)));
      end
      S_M2: begin
        mul_a = 33'(beat_q.gain_heading);
        mul_b = 33'(sat33(33'(beat_q.target_heading) - 33'(ph_q)));
      end
      S_M3: begin
        mul_a = 33'(rate_q);
        mul_b = {2'b00, ts_q};
      end
      S_Z0: begin
        mul_a = {2'b00, cs_q};
        mul_b = {2'b00, ts_q};
      end
      S_Z1: begin
        mul_a = 33'(t_q);
        mul_b = 33'(c0_q);
      end
      S_Z2: begin
        mul_a = 33'(d_q);
        mul_b = 33'(s0_q);
      end
      S_A1: begin
        mul_a = 33'(d_q);
        mul_b = 33'(s1_q) - 33'(s0_q);
      end
      S_A2: begin
        mul_a = 33'(d_q);
        mul_b = 33'(c0_q) - 33'(c1_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    t_d = fxmul(mul_a, mul_b);
  end

  // Datapath helpers for the clamp, the reducer and the divider.
  always_comb begin
    raw    = sat33(33'(acc_q) + 33'(t_q));
    rclamp = (raw < lo_q) ? lo_q : raw;
    rclamp = (rclamp > hi_q) ? hi_q : rclamp;
    absang = ang_q[31] ? -ang_q : ang_q;
    tp_k   = {{(MW - 33){1'b0}}, Q30_TWO_PI_U} << k_q;
    zs     = neg_q ? -{1'b0, m_q[32:0]} : {1'b0, m_q[32:0]};
    zw     = zs;
    if (zs > dpr_pkg::Q30_PI) begin
      zw = zs - dpr_pkg::Q30_TWO_PI;
    end else if (zs < -dpr_pkg::Q30_PI) begin
      zw = zs + dpr_pkg::Q30_TWO_PI;
    end
    trial  = {rem_q, dvd_q[DW-1]};
    if (!rate_q[31]) begin
      radius = (dvd_q > DW'(64'd2147483647)) ? 32'sh7fffffff : dvd_q[31:0];
    end else begin
      radius = (dvd_q > DW'(64'd2147483648)) ? 32'sh80000000 : -dvd_q[31:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_M0;
      S_M0:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_CLAMP;
      S_CLAMP: state_d = S_M3;
      S_M3:    state_d = S_YAW;
      S_YAW:   state_d = S_RSET;
      S_RSET:  state_d = S_RED;
      S_RED:   if (k_q == '0) state_d = S_FOLD1;
      S_FOLD1: state_d = S_FOLD2;
      S_FOLD2: state_d = S_CORD;
      S_CORD:  if (i_q == CW'(CORDIC_STEPS - 1)) state_d = S_CEND;
      S_CEND: begin
        if (pass_q) begin
          state_d = S_A1;
        end else if (rate_q == '0) begin
          state_d = S_Z0;
        end else begin
          state_d = S_DSET;
        end
      end
      S_Z0:    state_d = S_Z1;
      S_Z1:    state_d = S_Z2;
      S_Z2:    state_d = S_Z3;
      S_Z3:    state_d = S_DONE;
      S_DSET:  state_d = S_DIV;
      S_DIV:   if (dc_q == '0) state_d = S_DEND;
      S_DEND:  state_d = S_RSET;
      S_A1:    state_d = S_A2;
      S_A2:    state_d = S_A3;
      S_A3:    state_d = S_DONE;
      S_DONE:  if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cs_q        <= 31'd655360;
      ts_q        <= 31'd6554;
      hi_q        <= 32'sd131072;
      lo_q        <= -32'sd131072;
      px_q        <= '0;
      py_q        <= '0;
      ph_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          dpr_pkg::CFG_CRUISE_SPEED: cs_q <= cfg_data_i[30:0];
          dpr_pkg::CFG_TIME_STEP:    ts_q <= cfg_data_i[30:0];
          dpr_pkg::CFG_RATE_UPPER:   hi_q <= cfg_data_i;
          dpr_pkg::CFG_RATE_LOWER:   lo_q <= cfg_data_i;
          default:                   hi_q <= hi_q;
        endcase
      end
      if (accept && in_data_i.start_req) begin
        px_q <= in_data_i.init_x;
        py_q <= in_data_i.init_y;
        ph_q <= in_data_i.init_heading;
      end
      if (emit) begin
        px_q        <= nx_q;
        py_q        <= ny_q;
        ph_q        <= nyaw_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        beat_q <= in_data_i;
        acc_q  <= in_data_i.nominal_rate;
      end
      S_M0: t_q <= t_d;
      S_M1: begin
        acc_q <= sat33(33'(acc_q) + 33'(t_q));
        t_q   <= t_d;
      end
      S_M2: begin
        acc_q <= sat33(33'(acc_q) + 33'(t_q));
        t_q   <= t_d;
      end
      S_CLAMP: begin
        rate_q  <= rclamp;
        clamp_q <= (rclamp != raw);
      end
      S_M3: t_q <= t_d;
      S_YAW: begin
        nyaw_q <= sat33(33'(ph_q) + 33'(t_q));
        ang_q  <= ph_q;
        pass_q <= 1'b0;
      end
      S_RSET: begin
        m_q   <= {{(MW - 32){1'b0}}, absang} << SH;
        neg_q <= ang_q[31];
        k_q   <= KW'(RED_STEPS - 1);
      end
      S_RED: begin
        if (m_q >= tp_k) m_q <= m_q - tp_k;
        k_q <= k_q - 1'b1;
      end
      S_FOLD1: z_q <= zw;
      S_FOLD2: begin
        if (z_q > dpr_pkg::Q30_HALF_PI) begin
          z_q    <= dpr_pkg::Q30_PI - z_q;
          flip_q <= 1'b1;
        end else if (z_q < -dpr_pkg::Q30_HALF_PI) begin
          z_q    <= -dpr_pkg::Q30_PI - z_q;
          flip_q <= 1'b1;
        end else begin
          flip_q <= 1'b0;
        end
        x_q <= dpr_pkg::Q30_GAIN;
        y_q <= '0;
        i_q <= '0;
      end
      S_CORD: begin
        if (z_q >= 0) begin
          x_q <= x_q - (y_q >>> i_q);
          y_q <= y_q + (x_q >>> i_q);
          z_q <= z_q - dpr_pkg::atan_q30(5'(i_q));
        end else begin
          x_q <= x_q + (y_q >>> i_q);
          y_q <= y_q - (x_q >>> i_q);
          z_q <= z_q + dpr_pkg::atan_q30(5'(i_q));
        end
        i_q <= i_q + 1'b1;
      end
      S_CEND: begin
        if (pass_q) begin
          s1_q <= rnd30(y_q);
          c1_q <= rnd30(flip_q ? -x_q : x_q);
        end else begin
          s0_q <= rnd30(y_q);
          c0_q <= rnd30(flip_q ? -x_q : x_q);
        end
      end
      S_Z0: t_q <= t_d;
      S_Z1: begin
        d_q <= t_q;
        t_q <= t_d;
      end
      S_Z2: begin
        nx_q <= sat33(33'(px_q) + 33'(t_q));
        t_q  <= t_d;
      end
      S_Z3: ny_q <= sat33(33'(py_q) + 33'(t_q));
      S_DSET: begin
        dvd_q <= {cs_q, {FRAC_BITS{1'b0}}};
        rem_q <= '0;
        dvs_q <= rate_q[31] ? -rate_q : rate_q;
        dc_q  <= DCW'(DW - 1);
      end
      S_DIV: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_q <= 32'(trial - {1'b0, dvs_q});
          dvd_q <= {dvd_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= trial[31:0];
          dvd_q <= {dvd_q[DW-2:0], 1'b0};
        end
        dc_q <= dc_q - 1'b1;
      end
      S_DEND: begin
        d_q    <= radius;
        ang_q  <= nyaw_q;
        pass_q <= 1'b1;
      end
      S_A1: t_q <= t_d;
      S_A2: begin
        nx_q <= sat33(33'(px_q) + 33'(t_q));
        t_q  <= t_d;
      end
      S_A3: ny_q <= sat33(33'(py_q) + 33'(t_q));
      S_DONE: begin
        if (emit) begin
          out_q.next_x       <= nx_q;
          out_q.next_y       <= ny_q;
          out_q.next_heading <= nyaw_q;
          out_q.applied_rate <= rate_q;
          out_q.rate_clamped <= clamp_q;
        end
      end
      default: t_q <= t_q;
    endcase
  end

  // An accepted beat keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A clamped rate sits on one of the limits.
  a_clamp_on_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rate_clamped) |->
      (out_data_o.applied_rate == hi_q || out_data_o.applied_rate == lo_q))
    else $error("clamped rate is not a limit");

  // With ordered limits the applied rate stays inside them.
  a_rate_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lo_q <= hi_q) |->
      (out_data_o.applied_rate >= lo_q && out_data_o.applied_rate <= hi_q))
    else $error("applied rate outside limits");

  // A result is only staged from the final state.
  a_stage_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o)) |-> ($past(state_q) == S_DONE))
    else $error("result staged outside the final state");

endmodule
